// ===== rtl/grr_pkg.sv =====
// Shared types and constants of the glyph row rasterizer.
package grr_pkg;

    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_COLS = 5;
    localparam int BASE_X_W   = 15;
    localparam int BASE_Y_W   = 14;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_PIXEL_SCALE  = 3'd2;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;
    localparam logic [2:0] REG_TEXT_COLOR   = 3'd5;

    // One classified row waiting for the pixel sequencer.
    typedef struct packed {
        logic [GLYPH_COLS-1:0]      bits;
        logic signed [BASE_X_W-1:0] base_x;
        logic signed [BASE_Y_W-1:0] base_y;
    } row_job_t;

    // Effective drawing settings after clamping.
    typedef struct packed {
        logic [1:0]  scale;
        logic [11:0] width;
        logic [11:0] height;
    } draw_cfg_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_FLUSH
    } seq_state_t;

endpackage

// ===== rtl/grr_front.sv =====
// Front end: accepts character items, folds case, looks up the font row and
// computes the base coordinates of the row.
module grr_front (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,
    input  logic signed [11:0]    origin_x,
    input  logic signed [11:0]    origin_y,
    input  logic [1:0]            scale,
    output logic                  push_valid,
    input  logic                  push_ready,
    output grr_pkg::row_job_t     push_job
);
    import grr_pkg::*;

    typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

    function automatic glyph_t font_glyph(input logic [7:0] code);
        glyph_t g;
        g = '0;
        unique case (code)
            8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h33: g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
            8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            8'h35: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            8'h3A: g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00};
            8'h2C: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04, 5'h08};
            8'h2F: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

    logic [7:0]             char_code;
    logic [7:0]             char_position;
    logic [2:0]             glyph_row;
    logic [7:0]             folded_code;
    glyph_t                 glyph;
    logic [GLYPH_COLS-1:0]  row_bits;
    logic [9:0]             pos_scaled;
    logic [12:0]            pos_offset;
    logic [4:0]             row_offset;

    assign char_code     = s_axis_tdata[7:0];
    assign char_position = s_axis_tdata[15:8];
    assign glyph_row     = s_axis_tdata[18:16];

    // Lower-case letters share the upper-case glyphs.
    assign folded_code = (char_code >= 8'h61 && char_code <= 8'h7A) ?
                         (char_code - 8'h20) : char_code;
    assign glyph       = font_glyph(folded_code);
    assign row_bits    = (glyph_row < 3'(GLYPH_ROWS)) ? glyph[glyph_row] : '0;

    // Cell pitch is six dots: position*scale*6 as two shifted adds.
    assign pos_scaled = 10'(char_position) * 10'(scale);
    assign pos_offset = {1'b0, pos_scaled, 2'b00} + {2'b00, pos_scaled, 1'b0};
    assign row_offset = 5'(glyph_row) * 5'(scale);

    assign push_job.bits   = row_bits;
    assign push_job.base_x = BASE_X_W'(origin_x) + $signed({2'b00, pos_offset});
    assign push_job.base_y = BASE_Y_W'(origin_y) + $signed({9'd0, row_offset});

    // Rows without a lit dot are consumed here and never reach the queue.
    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid && (row_bits != '0);

endmodule

// ===== rtl/grr_queue.sv =====
// Two-entry queue between the front end and the pixel sequencer.
module grr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  grr_pkg::row_job_t  push_job,
    output logic               pop_valid,
    input  logic               pop,
    output grr_pkg::row_job_t  pop_job
);
    import grr_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    row_job_t               entries [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/grr_back.sv =====
// Back end: walks the lit dots of a row, clips each pixel, forms its address
// and holds one write back so that the final write of the row can be marked.
module grr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  grr_pkg::draw_cfg_t cfg,
    input  logic [23:0]        text_color,
    input  logic               job_valid,
    output logic               job_pop,
    input  grr_pkg::row_job_t  job,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [47:0]        m_axis_tdata,
    output logic               m_axis_tlast
);
    import grr_pkg::*;

    function automatic logic [2:0] first_col(input logic [GLYPH_COLS-1:0] m);
        logic [2:0] c;
        c = 3'd0;
        priority if (m[4]) c = 3'd0;
        else if (m[3])     c = 3'd1;
        else if (m[2])     c = 3'd2;
        else if (m[1])     c = 3'd3;
        else               c = 3'd4;
        return c;
    endfunction

    // Sequencer state.
    seq_state_t                 state_reg, state_next;
    logic [GLYPH_COLS-1:0]      mask_reg, mask_next;
    logic signed [BASE_X_W-1:0] bx_reg, bx_next;
    logic signed [BASE_Y_W-1:0] by_reg, by_next;
    logic [2:0]                 col_reg, col_next;
    logic [1:0]                 dx_reg, dx_next;
    logic [1:0]                 dy_reg, dy_next;

    // Candidate pixel stage.
    logic                       cand_v_reg;
    logic                       cand_keep_reg;
    logic                       cand_flush_reg;
    logic [11:0]                cand_x_reg;
    logic [11:0]                cand_y_reg;

    // Held write and output register.
    logic                       held_v_reg;
    logic [21:0]                held_addr_reg;
    logic                       out_v_reg;
    logic [21:0]                out_addr_reg;
    logic                       out_last_reg;

    logic                       issue;
    logic                       issue_flush;
    logic                       out_free;
    logic                       cand_go;
    logic                       cand_room;
    logic [GLYPH_COLS-1:0]      mask_left;
    logic [4:0]                 col_offset;
    logic signed [BASE_X_W-1:0] px;
    logic signed [BASE_Y_W-1:0] py;
    logic                       in_frame;
    logic [24:0]                addr_full;
    logic [1:0]                 scale_last;

    assign out_free  = !out_v_reg || m_axis_tready;
    assign cand_go   = cand_v_reg &&
                       (!(cand_keep_reg || cand_flush_reg) || !held_v_reg || out_free);
    assign cand_room = !cand_v_reg || cand_go;

    assign scale_last = cfg.scale - 2'd1;
    assign mask_left  = mask_reg & ~(5'b10000 >> col_reg);
    assign col_offset = 5'(col_reg) * 5'(cfg.scale);
    assign px = bx_reg + $signed({{(BASE_X_W-5){1'b0}}, col_offset})
                       + $signed({{(BASE_X_W-2){1'b0}}, dx_reg});
    assign py = by_reg + $signed({{(BASE_Y_W-2){1'b0}}, dy_reg});
    assign in_frame = !px[BASE_X_W-1] && !py[BASE_Y_W-1] &&
                      (px[BASE_X_W-2:0] < {{(BASE_X_W-13){1'b0}}, cfg.width}) &&
                      (py[BASE_Y_W-2:0] < {{(BASE_Y_W-13){1'b0}}, cfg.height});

    always_comb
    begin
        state_next  = state_reg;
        mask_next   = mask_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        col_next    = col_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        job_pop     = 1'b0;
        issue       = 1'b0;
        issue_flush = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    mask_next  = job.bits;
                    bx_next    = job.base_x;
                    by_next    = job.base_y;
                    col_next   = first_col(job.bits);
                    dx_next    = 2'd0;
                    dy_next    = 2'd0;
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (cand_room)
                begin
                    issue = 1'b1;
                    if (dx_reg != scale_last)
                    begin
                        dx_next = dx_reg + 2'd1;
                    end
                    else
                    begin
                        dx_next = 2'd0;
                        if (dy_reg != scale_last)
                        begin
                            dy_next = dy_reg + 2'd1;
                        end
                        else
                        begin
                            dy_next   = 2'd0;
                            mask_next = mask_left;
                            col_next  = first_col(mask_left);
                            if (mask_left == '0)
                            begin
                                state_next = SEQ_FLUSH;
                            end
                        end
                    end
                end
            end
            SEQ_FLUSH:
            begin
                if (cand_room)
                begin
                    issue_flush = 1'b1;
                    state_next  = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        col_reg  <= col_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_v_reg <= 1'b0;
        end
        else if (issue || issue_flush)
        begin
            cand_v_reg <= 1'b1;
        end
        else if (cand_go)
        begin
            cand_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue || issue_flush)
        begin
            cand_keep_reg  <= issue && in_frame;
            cand_flush_reg <= issue_flush;
            cand_x_reg     <= px[11:0];
            cand_y_reg     <= py[11:0];
        end
    end

    // Address of a kept pixel: y * width + x, cut to the word address width.
    assign addr_full = 25'(cand_y_reg * cfg.width) + 25'(cand_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cand_go && (cand_keep_reg || cand_flush_reg) && held_v_reg)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
            if (cand_go && cand_keep_reg)
            begin
                held_v_reg <= 1'b1;
            end
            else if (cand_go && cand_flush_reg)
            begin
                held_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_go && (cand_keep_reg || cand_flush_reg) && held_v_reg)
        begin
            out_addr_reg <= held_addr_reg;
            out_last_reg <= cand_flush_reg;
        end
        if (cand_go && cand_keep_reg)
        begin
            held_addr_reg <= addr_full[21:0];
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {2'b00, text_color, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/glyph_row_rasterizer.sv =====
// Top level of the glyph row rasterizer: configuration registers and wiring.
//
// Each input transfer on the s_axis channel names a character code, its index
// in the string and one font row. The block folds lower-case letters to upper
// case, looks the row up in a built-in 5x7 font and sends one m_axis transfer
// per framebuffer pixel to write: the word address y*width+x and the text
// colour. Every lit dot becomes a square of scale x scale pixels; pixels off
// the frame are dropped, and tlast marks the final write of each row. Rows
// with no visible pixel produce no transfer at all.
// Settings are written through the cfg channel (always ready); the user must
// write them only while the block is idle, which the block does not enforce.
// Throughput: one candidate pixel per cycle while the output is not stalled;
// rows with no lit dot are consumed at the input. A row's first write passes
// the queue, sequencer, candidate and held registers, since one write is held
// back to learn whether it is the last. A two-entry queue lets the front end
// take further rows while the sequencer works. A receiver stall freezes the
// output register and, behind it, the sequencer; no write is lost. Reset
// empties the queue and restores the default settings (640x480, scale 1,
// origin 0, white).
module glyph_row_rasterizer #(
    parameter int FRAME_SIDE_MAX = 2048,
    parameter int SCALE_MAX      = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], char_position[15:8], glyph_row[18:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pixel_address[21:0], pixel_color[45:22]
    output logic        m_axis_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import grr_pkg::*;

    // Clamp limits sized to the 12-bit frame registers.
    localparam logic [11:0] SIDE_CLAMP =
        (FRAME_SIDE_MAX > 4095) ? 12'd4095 : 12'(FRAME_SIDE_MAX);
    localparam logic [1:0]  SCALE_CLAMP = 2'(SCALE_MAX);

    logic signed [11:0] origin_x_reg;
    logic signed [11:0] origin_y_reg;
    logic [1:0]         pixel_scale_reg;
    logic [11:0]        frame_width_reg;
    logic [11:0]        frame_height_reg;
    logic [23:0]        text_color_reg;

    draw_cfg_t          draw_cfg;
    logic               push_valid;
    logic               push_ready;
    row_job_t           push_job;
    logic               job_valid;
    logic               job_pop;
    row_job_t           job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= 12'sd0;
            origin_y_reg     <= 12'sd0;
            pixel_scale_reg  <= 2'd1;
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 12'd480;
            text_color_reg   <= 24'hFFFFFF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data[11:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[11:0];
                REG_PIXEL_SCALE:  pixel_scale_reg  <= cfg_data[1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[11:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[11:0];
                REG_TEXT_COLOR:   text_color_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A scale of zero draws as one; oversize settings saturate.
    always_comb
    begin
        priority if (pixel_scale_reg == 2'd0)
            draw_cfg.scale = 2'd1;
        else if (pixel_scale_reg > SCALE_CLAMP)
            draw_cfg.scale = SCALE_CLAMP;
        else
            draw_cfg.scale = pixel_scale_reg;
        draw_cfg.width  = ({1'b0, frame_width_reg} > 13'(FRAME_SIDE_MAX)) ?
                          SIDE_CLAMP : frame_width_reg;
        draw_cfg.height = ({1'b0, frame_height_reg} > 13'(FRAME_SIDE_MAX)) ?
                          SIDE_CLAMP : frame_height_reg;
    end

    grr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .scale         (draw_cfg.scale),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    grr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (job_valid),
        .pop        (job_pop),
        .pop_job    (job)
    );

    grr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (draw_cfg),
        .text_color    (text_color_reg),
        .job_valid     (job_valid),
        .job_pop       (job_pop),
        .job           (job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
